/* design/gpsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpsl_pkg: shared constants and types for the gyro PID servo leveler
// Widths, fixed-point reciprocals, register indexes and reset values.
// ----------------------------------------------------------------------------
package gpsl_pkg;

  // Number of raw samples averaged into the zero offset.
  localparam int CAL_SAMPLES = 150;
  // Width of the saturating angle accumulator.
  localparam int ANGLE_BITS  = 40;

  localparam int SEEN_W  = $clog2(CAL_SAMPLES + 1);
  localparam int OFS_W   = 16 + $clog2(CAL_SAMPLES + 1);
  localparam int RATE_W  = 16;
  localparam int PULSE_W = 12;
  localparam int DB_W    = 15;
  localparam int ILIM_W  = 10;
  localparam int INT_W   = 11;
  localparam int Q_FRAC  = 24;

  // Divide-by-CAL_SAMPLES as a multiply by a rounded-up reciprocal.
  localparam int          CAL_SHIFT = 31;
  localparam logic [63:0] CAL_RECIP_W =
    ((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [31:0] CAL_RECIP = CAL_RECIP_W[31:0];

  // Q24 reciprocals of the controller gains.
  localparam logic signed [13:0] RECIP_P = 14'sd2204;
  localparam logic signed [13:0] RECIP_I = 14'sd4409;
  localparam logic signed [13:0] RECIP_D = 14'sd4793;

  // Opcode of a control tick; any other value is a rate sample.
  localparam logic OP_TICK = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_BAND      = 3'd0,
    REG_INTEGRAL_LIMIT = 3'd1,
    REG_CENTER_PULSE   = 3'd2,
    REG_MIN_PULSE      = 3'd3,
    REG_MAX_PULSE      = 3'd4
  } cfg_reg_t;

  localparam logic [DB_W-1:0]    DEAD_BAND_RST      = 15'd45;
  localparam logic [ILIM_W-1:0]  INTEGRAL_LIMIT_RST = 10'd500;
  localparam logic [PULSE_W-1:0] CENTER_PULSE_RST   = 12'd1500;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST      = 12'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST      = 12'd2000;
  localparam logic [PULSE_W-1:0] PULSE_RST          = 12'd1500;

endpackage

/* design/gyro_pid_servo_leveler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_pid_servo_leveler_top: gyro-driven PID servo leveler
// Calibrates a gyro zero offset, integrates the corrected rate into an angle
// and turns each control tick into a clamped servo pulse width.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   -------   ----------------------   -------------------------------------
//   item      item_valid / item_stall  opcode, gyro_raw
//   result    result_valid / result_stall  pulse_us, saturated, calibrating
//   cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each accepted word yields one result word: the input register passes it
// to the controller state, which doubles as the result register. A new word
// can be taken in every cycle while item_stall is low. Reset is synchronous
// and active high and restores the register defaults and a 1500 us pulse.
// Under result_stall the input register takes one more word, then item_stall
// rises. The cfg port is always ready and should only be written while idle.
//
// Rate samples: the first CAL_SAMPLES samples are summed and their average,
// truncated toward zero, becomes the zero offset. The divide by CAL_SAMPLES
// is a multiply by a rounded-up Q31 reciprocal, which is exact over the full
// range of the sum. Later samples are offset-corrected with saturation,
// forced to zero inside the dead band and added to a saturating angle.
//
// Control ticks: the angle is clamped to +-2^32 for the multipliers, the
// integral is updated with truncation toward zero and clamped to the limit,
// and the Q24 duty value is compared against the pulse limits (max first).
// Ticks during calibration leave the pulse and the flag unchanged.
// ----------------------------------------------------------------------------
module gyro_pid_servo_leveler_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // input word channel
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  opcode,
  input  logic signed [gpsl_pkg::RATE_W-1:0]    gyro_raw,
  // result word channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [gpsl_pkg::PULSE_W-1:0]          pulse_us,
  output logic                                  saturated,
  output logic                                  calibrating,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gpsl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gpsl_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gpsl_pkg::*;

  localparam int AEXT_W = 66;
  localparam int DP_W   = 34;
  localparam int PI_W   = 48;
  localparam int IS_W   = 50;
  localparam int IN_W   = IS_W - Q_FRAC;
  localparam int DUTY_W = 48;
  localparam int QUO_W  = 17;

  localparam logic signed [ANGLE_BITS-1:0] ANG_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
  localparam logic signed [ANGLE_BITS-1:0] ANG_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [AEXT_W-1:0]     DP_HI   = 66'sd4294967296;
  localparam logic signed [AEXT_W-1:0]     DP_LO   = -66'sd4294967296;

  // Configuration registers.
  logic [DB_W-1:0]    dead_band;
  logic [ILIM_W-1:0]  integral_limit;
  logic [PULSE_W-1:0] center_pulse;
  logic [PULSE_W-1:0] min_pulse;
  logic [PULSE_W-1:0] max_pulse;

  // Input register.
  logic                     in_full;
  logic                     in_op;
  logic signed [RATE_W-1:0] in_raw;
  logic                     advance;

  // Controller state.
  logic [SEEN_W-1:0]            samples_seen;
  logic signed [OFS_W-1:0]      offset_sum;
  logic signed [RATE_W-1:0]     zero_offset;
  logic signed [ANGLE_BITS-1:0] angle_sum;
  logic signed [INT_W-1:0]      integral_term;
  logic signed [RATE_W-1:0]     last_rate;
  logic [PULSE_W-1:0]           pulse_width;
  logic                         sat_flag;

  logic [SEEN_W-1:0]            samples_seen_next;
  logic signed [OFS_W-1:0]      offset_sum_next;
  logic signed [RATE_W-1:0]     zero_offset_next;
  logic signed [ANGLE_BITS-1:0] angle_sum_next;
  logic signed [INT_W-1:0]      integral_term_next;
  logic signed [RATE_W-1:0]     last_rate_next;
  logic [PULSE_W-1:0]           pulse_width_next;
  logic                         sat_flag_next;

  // Datapath signals.
  logic                          cal_active;
  logic [OFS_W-1:0]              ofs_mag;
  logic [OFS_W+31:0]             ofs_prod;
  logic [QUO_W-1:0]              ofs_quo;
  logic [QUO_W-1:0]              ofs_avg;
  logic signed [RATE_W:0]        rate_diff;
  logic signed [RATE_W-1:0]      rate_sat;
  logic [RATE_W:0]               rate_mag;
  logic signed [RATE_W-1:0]      rate_db;
  logic signed [ANGLE_BITS:0]    angle_add;
  logic signed [AEXT_W-1:0]      angle_ext;
  logic signed [DP_W-1:0]        ang_c;
  logic signed [PI_W-1:0]        prod_i;
  logic signed [IS_W-1:0]        isum;
  logic signed [IN_W-1:0]        inew_raw;
  logic signed [IN_W-1:0]        ilim_s;
  logic signed [INT_W-1:0]       inew;
  logic signed [DUTY_W-1:0]      prod_p;
  logic signed [DUTY_W-1:0]      prod_d;
  logic signed [DUTY_W-1:0]      duty;
  logic signed [DUTY_W-1:0]      max_q;
  logic signed [DUTY_W-1:0]      min_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band      <= DEAD_BAND_RST;
      integral_limit <= INTEGRAL_LIMIT_RST;
      center_pulse   <= CENTER_PULSE_RST;
      min_pulse      <= MIN_PULSE_RST;
      max_pulse      <= MAX_PULSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEAD_BAND:      dead_band      <= cfg_data[DB_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[ILIM_W-1:0];
        REG_CENTER_PULSE:   center_pulse   <= cfg_data[PULSE_W-1:0];
        REG_MIN_PULSE:      min_pulse      <= cfg_data[PULSE_W-1:0];
        REG_MAX_PULSE:      max_pulse      <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the input register moves into the state whenever the result
  // register is empty or its word is being taken.
  // --------------------------------------------------------------------------
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_op  <= opcode;
      in_raw <= gyro_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Calibration: running sum and the final average, truncated toward zero.
  // --------------------------------------------------------------------------
  assign cal_active      = samples_seen < SEEN_W'(CAL_SAMPLES);
  assign offset_sum_next = offset_sum + OFS_W'(in_raw);

  always_comb begin
    ofs_mag  = offset_sum_next[OFS_W-1] ? OFS_W'(-offset_sum_next) : OFS_W'(offset_sum_next);
    ofs_prod = (OFS_W+32)'(ofs_mag) * (OFS_W+32)'(CAL_RECIP);
    ofs_quo  = ofs_prod[CAL_SHIFT +: QUO_W];
    ofs_avg  = offset_sum_next[OFS_W-1] ? (~ofs_quo + QUO_W'(1)) : ofs_quo;
  end

  // --------------------------------------------------------------------------
  // Rate path: offset correction, dead band and saturating angle.
  // --------------------------------------------------------------------------
  always_comb begin
    rate_diff = {in_raw[RATE_W-1], in_raw} - {zero_offset[RATE_W-1], zero_offset};
    if (!rate_diff[RATE_W] && rate_diff[RATE_W-1]) begin
      rate_sat = {1'b0, {(RATE_W-1){1'b1}}};
    end else if (rate_diff[RATE_W] && !rate_diff[RATE_W-1]) begin
      rate_sat = {1'b1, {(RATE_W-1){1'b0}}};
    end else begin
      rate_sat = rate_diff[RATE_W-1:0];
    end
    // A 17-bit magnitude keeps the most negative rate outside every dead band.
    rate_mag = rate_sat[RATE_W-1] ? (RATE_W+1)'(-$signed({rate_sat[RATE_W-1], rate_sat}))
                                  : (RATE_W+1)'(rate_sat);
    rate_db  = (rate_mag <= (RATE_W+1)'(dead_band)) ? '0 : rate_sat;

    angle_add = (ANGLE_BITS+1)'(angle_sum) + (ANGLE_BITS+1)'(rate_db);
    if (!angle_add[ANGLE_BITS] && angle_add[ANGLE_BITS-1]) begin
      angle_sum_next = ANG_MAX;
    end else if (angle_add[ANGLE_BITS] && !angle_add[ANGLE_BITS-1]) begin
      angle_sum_next = ANG_MIN;
    end else begin
      angle_sum_next = angle_add[ANGLE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Tick path: integral with anti-windup and the Q24 pulse computation.
  // --------------------------------------------------------------------------
  always_comb begin
    angle_ext = AEXT_W'(angle_sum);
    if (angle_ext > DP_HI) begin
      ang_c = DP_HI[DP_W-1:0];
    end else if (angle_ext < DP_LO) begin
      ang_c = DP_LO[DP_W-1:0];
    end else begin
      ang_c = angle_ext[DP_W-1:0];
    end

    prod_i = PI_W'(ang_c) * PI_W'(RECIP_I);
    isum   = (IS_W'(integral_term) <<< Q_FRAC) + IS_W'(prod_i);
    // Arithmetic shift floors; step negative values with a fraction back up.
    inew_raw = IN_W'(isum >>> Q_FRAC);
    if (isum[IS_W-1] && (isum[Q_FRAC-1:0] != '0)) begin
      inew_raw = inew_raw + IN_W'(1);
    end
    ilim_s = IN_W'(integral_limit);
    if (inew_raw > ilim_s) begin
      inew = INT_W'(ilim_s);
    end else if (inew_raw < -ilim_s) begin
      inew = INT_W'(-ilim_s);
    end else begin
      inew = INT_W'(inew_raw);
    end

    prod_p = DUTY_W'(ang_c) * DUTY_W'(RECIP_P);
    prod_d = DUTY_W'(last_rate) * DUTY_W'(RECIP_D);
    duty   = $signed({12'd0, center_pulse, 24'd0})
             - (prod_p + (DUTY_W'(inew) <<< Q_FRAC) + prod_d);
    max_q  = $signed({12'd0, max_pulse, 24'd0});
    min_q  = $signed({12'd0, min_pulse, 24'd0});
  end

  // --------------------------------------------------------------------------
  // Next state selection.
  // --------------------------------------------------------------------------
  always_comb begin
    samples_seen_next  = samples_seen;
    zero_offset_next   = zero_offset;
    last_rate_next     = last_rate;
    integral_term_next = integral_term;
    pulse_width_next   = pulse_width;
    sat_flag_next      = sat_flag;

    if (in_op != OP_TICK) begin
      if (cal_active) begin
        samples_seen_next = samples_seen + SEEN_W'(1);
        if (samples_seen_next == SEEN_W'(CAL_SAMPLES)) begin
          zero_offset_next = ofs_avg[RATE_W-1:0];
        end
      end else begin
        last_rate_next = rate_db;
      end
    end else if (!cal_active) begin
      integral_term_next = inew;
      if (duty > max_q) begin
        pulse_width_next = max_pulse;
        sat_flag_next    = 1'b1;
      end else if (duty < min_q) begin
        pulse_width_next = min_pulse;
        sat_flag_next    = 1'b1;
      end else begin
        pulse_width_next = duty[Q_FRAC +: PULSE_W];
        sat_flag_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen  <= '0;
      offset_sum    <= '0;
      zero_offset   <= '0;
      angle_sum     <= '0;
      integral_term <= '0;
      last_rate     <= '0;
      pulse_width   <= PULSE_RST;
      sat_flag      <= 1'b0;
    end else if (advance) begin
      samples_seen  <= samples_seen_next;
      zero_offset   <= zero_offset_next;
      last_rate     <= last_rate_next;
      integral_term <= integral_term_next;
      pulse_width   <= pulse_width_next;
      sat_flag      <= sat_flag_next;
      if (in_op != OP_TICK) begin
        if (cal_active) begin
          offset_sum <= offset_sum_next;
        end else begin
          angle_sum  <= angle_sum_next;
        end
      end
    end
  end

  // The state only moves when a new result word is loaded, so it is the
  // result payload and holds steady under result_stall.
  assign pulse_us    = pulse_width;
  assign saturated   = sat_flag;
  assign calibrating = cal_active;

endmodule
